// ===== design/swms_pkg.sv =====
// Package for the sliding-window max sparkline block.
// Holds field widths, command codes and payload structs. No dependencies.
`timescale 1ns / 1ps

package swms_pkg;

	localparam int WINDOW_LEN_DEF = 32;
	localparam int SAMPLE_W       = 32;
	localparam int MAX_W          = 31;
	localparam int LEVEL_W        = 3;
	localparam int ALU_W          = 37;

	localparam logic [LEVEL_W-1:0] LEVEL_TOP = 3'd6;

	localparam logic CMD_PUSH   = 1'b0;
	localparam logic CMD_RENDER = 1'b1;

	typedef struct packed {
		logic                       cmd;
		logic signed [SAMPLE_W-1:0] sample;
	} req_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               last;
	} rsp_t;

endpackage

// ===== design/swms_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// No dependencies; the payload type is set per instance.
`timescale 1ns / 1ps

interface swms_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/swms_ring.sv =====
// Sample ring storage: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses swms_pkg.
`timescale 1ns / 1ps

module swms_ring
	import swms_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int IDX_W      = $clog2(WINDOW_LEN)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [IDX_W-1:0]           waddr,
	input  logic signed [SAMPLE_W-1:0] wdata,
	input  logic                       re,
	input  logic [IDX_W-1:0]           raddr,
	output logic signed [SAMPLE_W-1:0] rdata
);

	logic signed [SAMPLE_W-1:0] mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]      vld_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic                       rv_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (re) begin
				rv_q <= vld_q[raddr];
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rv_q ? rd_q : '0;

endmodule

// ===== design/swms_alu.sv =====
// Shared subtract/compare unit used by the push, rescan and divide steps.
// Signed operands of ALU_W bits. Uses swms_pkg.
`timescale 1ns / 1ps

module swms_alu
	import swms_pkg::*;
(
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output logic [ALU_W-1:0] diff,
	output logic             ge,
	output logic             zero
);

	// operands are kept well inside range, so the sign of a-b never overflows
	assign diff = a - b;
	assign ge   = ~diff[ALU_W-1];
	assign zero = (diff == '0);

endmodule

// ===== design/sliding_window_max_sparkline.sv =====
// Top level of the sliding-window max sparkline block.
// Depends on swms_pkg, swms_stream_if, swms_ring and swms_alu.
`timescale 1ns / 1ps

//  channel | dir | payload                      | notes
//  --------+-----+------------------------------+-------------------------------
//  req     | in  | cmd (0 push, 1 render),      | one transfer per command
//          |     | sample (signed 32)           |
//  rsp     | out | level (0..6), last           | WINDOW_LEN transfers per render
//
//  Push steps: accept, evict/raise max, compare. When the evicted sample
//  equals the maximum, a rescan walks the ring through the memory read port.
//  Render, per level: read, load 7*s, three restoring divide steps, hand-off.
//  Reset clears per-entry valid bits at once, so no clearing pass is needed.
//  A stalled rsp holds the render at its hand-off step; req is not ready
//  while a command is in progress.

module sliding_window_max_sparkline
	import swms_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	swms_stream_if.sink   req,
	swms_stream_if.source rsp
);

	localparam int IDX_W = $clog2(WINDOW_LEN);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_LEN - 1);
	localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(WINDOW_LEN - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW_LEN);
	localparam logic [IDX_W:0]   WIN_WIDE  = (IDX_W + 1)'(WINDOW_LEN);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_P_EVICT = 8'b0000_0010,
		ST_P_CHK   = 8'b0000_0100,
		ST_SCAN    = 8'b0000_1000,
		ST_R_RD    = 8'b0001_0000,
		ST_R_LD    = 8'b0010_0000,
		ST_R_DIV   = 8'b0100_0000,
		ST_R_OUT   = 8'b1000_0000
	} state_t;

	state_t                     state_q;
	logic [IDX_W-1:0]           slot_q;
	logic [MAX_W-1:0]           max_q;
	logic signed [SAMPLE_W-1:0] smp_q;
	logic signed [SAMPLE_W-1:0] evict_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       pend_q;
	logic [ALU_W-1:0]           rem_q;
	logic [LEVEL_W-1:0]         quo_q;
	logic [1:0]                 step_q;
	logic                       out_vld_q;
	logic [LEVEL_W-1:0]         out_level_q;
	logic                       out_last_q;

	// ring ports
	logic                       ring_we;
	logic                       ring_re;
	logic [IDX_W-1:0]           ring_raddr;
	logic signed [SAMPLE_W-1:0] ring_rdata;

	// shared unit ports
	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic [ALU_W-1:0] alu_diff;
	logic             alu_ge;
	logic             alu_zero;

	logic             acc;
	logic [IDX_W:0]   rd_sum;
	logic [IDX_W-1:0] rend_addr;
	logic [ALU_W-1:0] max_ext;
	logic [ALU_W-1:0] dvs;
	logic [ALU_W-1:0] pos_ext;
	logic             out_load;
	logic             scan_more;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;

	assign rsp.valid         = out_vld_q;
	assign rsp.payload.level = out_level_q;
	assign rsp.payload.last  = out_last_q;

	// render reads walk from the oldest slot and wrap around the window
	assign rd_sum    = {1'b0, slot_q} + cnt_q[IDX_W:0];
	assign rend_addr = (rd_sum >= WIN_WIDE) ? IDX_W'(rd_sum - WIN_WIDE) : rd_sum[IDX_W-1:0];

	assign scan_more = (cnt_q < FULL_CNT);

	always_comb begin
		ring_re    = 1'b0;
		ring_raddr = slot_q;
		if (acc && req.payload.cmd == CMD_PUSH) begin
			ring_re = 1'b1;
		end else if (state_q == ST_SCAN) begin
			ring_re    = scan_more;
			ring_raddr = cnt_q[IDX_W-1:0];
		end else if (state_q == ST_R_RD) begin
			ring_re    = 1'b1;
			ring_raddr = rend_addr;
		end
	end

	assign ring_we = (state_q == ST_P_EVICT);

	swms_ring #(
		.WINDOW_LEN (WINDOW_LEN),
		.IDX_W      (IDX_W)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ring_we),
		.waddr  (slot_q),
		.wdata  (smp_q),
		.re     (ring_re),
		.raddr  (ring_raddr),
		.rdata  (ring_rdata)
	);

	assign max_ext = {{(ALU_W-MAX_W){1'b0}}, max_q};
	assign dvs     = max_ext + ALU_W'(1);
	// positive part of a read sample, for 7*s
	assign pos_ext = {{(ALU_W-MAX_W){1'b0}}, ring_rdata[MAX_W-1:0]};

	// operand select for the shared subtractor
	always_comb begin
		alu_a = max_ext;
		alu_b = {{(ALU_W-SAMPLE_W){ring_rdata[SAMPLE_W-1]}}, ring_rdata};
		unique case (state_q)
			ST_P_EVICT: begin
				alu_b = {{(ALU_W-SAMPLE_W){smp_q[SAMPLE_W-1]}}, smp_q};
			end
			ST_P_CHK: begin
				alu_a = {{(ALU_W-SAMPLE_W){evict_q[SAMPLE_W-1]}}, evict_q};
				alu_b = max_ext;
			end
			ST_R_DIV: begin
				alu_a = rem_q;
				alu_b = dvs << step_q;
			end
			default: begin
			end
		endcase
	end

	swms_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge),
		.zero (alu_zero)
	);

	assign out_load = (state_q == ST_R_OUT) && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			slot_q    <= '0;
			max_q     <= '0;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// output register: a new level replaces a taken one in the same cycle
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cnt_q <= '0;
						if (req.payload.cmd == CMD_PUSH) begin
							state_q <= ST_P_EVICT;
						end else begin
							state_q <= ST_R_RD;
						end
					end
				end
				ST_P_EVICT: begin
					// new sample is written this cycle; raise the max if it is larger
					if (!alu_ge) begin
						max_q <= smp_q[MAX_W-1:0];
					end
					slot_q  <= (slot_q == LAST_IDX) ? '0 : slot_q + IDX_W'(1);
					state_q <= ST_P_CHK;
				end
				ST_P_CHK: begin
					if (alu_zero) begin
						// evicted value was the max: rebuild it from zero
						max_q   <= '0;
						cnt_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					pend_q <= scan_more;
					if (scan_more) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (pend_q && !alu_ge) begin
						max_q <= ring_rdata[MAX_W-1:0];
					end
					if (!scan_more && !pend_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_R_RD: begin
					state_q <= ST_R_LD;
				end
				ST_R_LD: begin
					step_q  <= 2'd2;
					state_q <= ST_R_DIV;
				end
				ST_R_DIV: begin
					if (step_q == 2'd0) begin
						state_q <= ST_R_OUT;
					end else begin
						step_q <= step_q - 2'd1;
					end
				end
				ST_R_OUT: begin
					if (out_load) begin
						if (cnt_q == LAST_CNT) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= ST_R_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			smp_q <= req.payload.sample;
		end
		if (state_q == ST_P_EVICT) begin
			evict_q <= ring_rdata;
		end
		if (state_q == ST_R_LD) begin
			quo_q <= '0;
			// negative or zero samples give level 0
			if (!ring_rdata[SAMPLE_W-1]) begin
				rem_q <= (pos_ext << 3) - pos_ext;
			end else begin
				rem_q <= '0;
			end
		end
		if (state_q == ST_R_DIV && alu_ge) begin
			rem_q         <= alu_diff;
			quo_q[step_q] <= 1'b1;
		end
		if (out_load) begin
			out_level_q <= (quo_q > LEVEL_TOP) ? LEVEL_TOP : quo_q;
			out_last_q  <= (cnt_q == LAST_CNT);
		end
	end

endmodule

// ===== bench/tb_sliding_window_max_sparkline.sv =====
// Testbench for sliding_window_max_sparkline: push/render stimulus with a
// scoreboard of predicted bar levels. Depends on swms_pkg, swms_stream_if and the block.
`timescale 1ns / 1ps

module tb_sliding_window_max_sparkline;
	import swms_pkg::*;

	localparam int WIN      = WINDOW_LEN_DEF;
	localparam int HALF_CLK = 4;
	localparam int IDLE_PCT = 36;

	logic clk;
	logic arst_n;

	swms_stream_if #(.payload_t(req_t)) req_if ();
	swms_stream_if #(.payload_t(rsp_t)) rsp_if ();

	sliding_window_max_sparkline #(
		.WINDOW_LEN(WIN)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#HALF_CLK;
		clk = 1'b1;
		#HALF_CLK;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the block state, advanced on every accepted command.
	// ------------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] shadow_ring [WIN];
	int unsigned                shadow_head;
	logic [MAX_W-1:0]           shadow_peak;

	// Levels still owed by the block, oldest first.
	rsp_t level_q [$];

	int  err_count;
	bit  src_idle_en;    // sender inserts random gaps
	bit  snk_idle_en;    // receiver drops ready at random
	int  snk_hold_left;  // cycles the receiver refuses every transfer

	// Peak restarts at zero, so an all-negative window yields zero.
	function automatic logic [MAX_W-1:0] scan_peak();
		logic signed [SAMPLE_W-1:0] best;
		best = '0;
		for (int k = 0; k < WIN; k++) begin
			if (shadow_ring[k] > best)
				best = shadow_ring[k];
		end
		return best[MAX_W-1:0];
	endfunction

	function automatic void shadow_push(logic signed [SAMPLE_W-1:0] incoming);
		logic signed [SAMPLE_W-1:0] evicted;
		evicted = shadow_ring[shadow_head];
		shadow_ring[shadow_head] = incoming;
		if (longint'(incoming) > longint'(shadow_peak))
			shadow_peak = incoming[MAX_W-1:0];
		// Evicting the peak (even one just re-set by the new sample) forces a rescan.
		if (longint'(evicted) == longint'(shadow_peak))
			shadow_peak = scan_peak();
		shadow_head = (shadow_head + 1) % WIN;
	endfunction

	// Queue one level per slot, oldest slot first, last flag on the final one.
	function automatic void queue_levels();
		longint unsigned divisor;
		longint unsigned prod;
		longint unsigned q;
		logic signed [SAMPLE_W-1:0] s;
		rsp_t r;
		divisor = longint'(shadow_peak) + 1;
		for (int k = 0; k < WIN; k++) begin
			s = shadow_ring[(shadow_head + k) % WIN];
			r.level = '0;
			if (s > 0) begin
				prod = longint'(s) * 7;
				q = prod / divisor;
				r.level = (q > LEVEL_TOP) ? LEVEL_TOP : q[LEVEL_W-1:0];
			end
			r.last = (k == WIN - 1);
			level_q.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Command sender: one transfer per call. Valid is only changed once per
	// falling edge, so back-to-back commands keep it high without a glitch.
	// ------------------------------------------------------------------
	task automatic send_cmd(input logic c, input logic signed [SAMPLE_W-1:0] s);
		@(negedge clk);
		while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= '{cmd: c, sample: s};
		do
			@(posedge clk);
		while (!req_if.ready);
		if (c == CMD_PUSH)
			shadow_push(s);
		else
			queue_levels();
	endtask

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
		send_cmd(CMD_PUSH, s);
	endtask

	// Sample on a render is don't-care; send junk to exercise the bits anyway.
	task automatic render_all();
		send_cmd(CMD_RENDER, $urandom());
	endtask

	task automatic release_valid();
		@(negedge clk);
		req_if.valid <= 1'b0;
	endtask

	// Sender stops until every owed level has come back.
	task automatic wait_drain();
		release_valid();
		while (level_q.size() != 0)
			@(posedge clk);
		// let a trailing rescan finish
		repeat (2 * WIN + 8) @(posedge clk);
	endtask

	// Mix of value classes; the small pool and peak copies make peak evictions common.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom();
			2, 3, 4: return $urandom_range(0, 15);
			5:       return -$signed($urandom_range(1, 1000));
			6: begin
				case ($urandom_range(0, 4))
					0:       return 32'sh7FFF_FFFF;
					1:       return 32'sh8000_0000;
					2:       return 32'sh0000_0000;
					3:       return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			7, 8:    return $signed({1'b0, shadow_peak});
			default: return $urandom_range(0, 32'h00FF_FFFF);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Receiver: ready changes at the falling edge; a hold-off beats idling.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (snk_hold_left > 0) begin
			rsp_if.ready  <= 1'b0;
			snk_hold_left <= snk_hold_left - 1;
		end else begin
			rsp_if.ready <= !(snk_idle_en && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Scoreboard: every level transfer is matched against the oldest prediction.
	always @(posedge clk) begin : level_check
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (level_q.size() == 0) begin
				err_count++;
				$display("%0t: unexpected level transfer level=%0d last=%0b",
					$time, rsp_if.payload.level, rsp_if.payload.last);
			end else begin
				want = level_q.pop_front();
				if (rsp_if.payload.level !== want.level) begin
					err_count++;
					$display("%0t: level mismatch expected %0d actual %0d",
						$time, want.level, rsp_if.payload.level);
				end
				if (rsp_if.payload.last !== want.last) begin
					err_count++;
					$display("%0t: last mismatch expected %0b actual %0b",
						$time, want.last, rsp_if.payload.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset window, extremes of the sample range, negative clamp, plain renders.
	task automatic test_directed();
		render_all();                   // all zero, peak zero
		push_sample(32'sh7FFF_FFFF);    // largest sample, 64-bit product
		render_all();
		push_sample(32'sh8000_0000);    // most negative, clamps to 0
		push_sample(-32'sd1);
		push_sample(32'sd1);
		push_sample(32'sd0);
		render_all();
		push_sample(32'sd1000);
		push_sample(32'sd3);
		push_sample(32'sh4000_0000);
		render_all();
		push_sample(32'sh7FFF_FFFE);
		push_sample(32'sh7FFF_FFFF);    // equal to peak, no raise
		render_all();
		wait_drain();
	endtask

	// Wrap the ring several times with small values so that evicting the
	// peak (including re-pushing the same peak value) happens often.
	task automatic test_peak_eviction();
		for (int lap = 0; lap < 3; lap++) begin
			for (int k = 0; k < WIN; k++) begin
				if ($urandom_range(0, 3) == 0)
					push_sample($signed({1'b0, shadow_peak}));
				else
					push_sample($urandom_range(0, 9));
				if (k % 11 == 10)
					render_all();
			end
			render_all();
		end
	endtask

	// A full window of negatives pushes out every positive: peak falls to zero.
	task automatic test_all_negative();
		for (int k = 0; k < WIN; k++)
			push_sample(-$signed($urandom_range(1, 32'h7FFF_FFFF)));
		render_all();
		push_sample(32'sd5);
		render_all();
	endtask

	// Receiver stalls long enough for the render to park and req to back up.
	task automatic test_backpressure();
		wait_drain();
		@(negedge clk);
		snk_hold_left = 400;
		render_all();
		for (int k = 0; k < 5; k++)
			push_sample(pick_sample());
		render_all();
		wait_drain();
	endtask

	// Long stretch at full rate on both sides.
	task automatic test_full_rate();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		for (int k = 0; k < 40; k++) begin
			if ($urandom_range(0, 4) == 0)
				render_all();
			else
				push_sample(pick_sample());
		end
		wait_drain();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
	endtask

	task automatic test_random_mix(input int n_items);
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 4) == 0)
				render_all();
			else
				push_sample(pick_sample());
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		rsp_if.ready   = 1'b0;
		err_count      = 0;
		src_idle_en    = 1'b1;
		snk_idle_en    = 1'b1;
		snk_hold_left  = 0;
		shadow_head    = 0;
		shadow_peak    = '0;
		for (int k = 0; k < WIN; k++)
			shadow_ring[k] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_peak_eviction();
		test_all_negative();
		test_backpressure();
		test_full_rate();
		test_random_mix(217);

		wait_drain();

		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/swms_pkg.sv
design/swms_stream_if.sv
design/swms_ring.sv
design/swms_alu.sv
design/sliding_window_max_sparkline.sv
bench/tb_sliding_window_max_sparkline.sv
